FILE: sv/spq_pkg.sv
// Package for the stable priority queue unit: sizes, item structs, codes,
// and the command and status structs between controller and datapath.
// Depends on nothing; every other file imports it.
package spq_pkg;

  // Queue sizing and stored field widths.
  localparam int unsigned CAPACITY     = 16;
  localparam int unsigned LEVEL_WIDTH  = 8;
  localparam int unsigned HANDLE_WIDTH = 16;

  // Index width for one entry and width of the entry count.
  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Width of the occupancy field in a result item.
  localparam int unsigned OCC_W = 5;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_e;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  // One input item.
  typedef struct packed {
    logic        kind;
    logic [7:0]  level;
    logic [15:0] item;
  } req_t;

  // One result item.
  typedef struct packed {
    logic [1:0]       status;
    logic [15:0]      item_out;
    logic [7:0]       level_out;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE,
    S_POP
  } state_e;

  // Datapath operations, one per cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_START_INS,
    OP_START_REM,
    OP_SHIFT,
    OP_PLACE,
    OP_POP,
    OP_FULL,
    OP_EMPTY
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic pos_one;
    logic goes_before;
  } stat_t;

endpackage

FILE: sv/spq_datapath.sv
// Datapath of the stable priority queue unit: entry memory as a ring,
// head pointer, entry count, insert position, and the result register.
// Depends on spq_pkg.
module spq_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  spq_pkg::req_t  req_i,
  input  spq_pkg::cmd_t  cmd_i,
  output spq_pkg::stat_t stat_o,
  output logic           done_o,
  output spq_pkg::result_t result_o
);
  import spq_pkg::*;

  typedef struct packed {
    logic [LEVEL_WIDTH-1:0]  level;
    logic [HANDLE_WIDTH-1:0] handle;
  } entry_t;

  // Maps a position in queue order to a memory address.
  function automatic logic [AW-1:0] phys(logic [AW-1:0] h, logic [AW-1:0] j);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, j};
    if (s >= (AW+1)'(CAPACITY)) begin
      s = s - (AW+1)'(CAPACITY);
    end
    return s[AW-1:0];
  endfunction

  entry_t mem_q [CAPACITY];
  entry_t rd_q;

  logic [CW-1:0]           count_q, count_d;
  logic [AW-1:0]           head_q, head_d;
  logic [AW-1:0]           pos_q, pos_d;
  logic [LEVEL_WIDTH-1:0]  lvl_q, lvl_d;
  logic [HANDLE_WIDTH-1:0] hdl_q, hdl_d;
  logic                    valid_q, valid_d;
  result_t                 res_q, res_d;

  logic                    rd_en;
  logic [AW-1:0]           rd_log;
  logic                    wr_en;
  entry_t                  wr_data;
  logic [CW-1:0]           count_m1;
  logic [CW-1:0]           count_p1;

  assign count_m1 = count_q - CW'(1);
  assign count_p1 = count_q + CW'(1);

  assign stat_o.empty       = (count_q == '0);
  assign stat_o.full        = (count_q == CW'(CAPACITY));
  assign stat_o.pos_one     = (pos_q == AW'(1));
  assign stat_o.goes_before = (lvl_q > rd_q.level);

  always_comb begin
    count_d = count_q;
    head_d  = head_q;
    pos_d   = pos_q;
    lvl_d   = lvl_q;
    hdl_d   = hdl_q;
    rd_en   = 1'b0;
    rd_log  = '0;
    wr_en   = 1'b0;
    wr_data = rd_q;
    valid_d = 1'b0;
    res_d   = res_q;
    unique case (cmd_i.op)
      OP_START_INS: begin
        lvl_d  = LEVEL_WIDTH'(req_i.level);
        hdl_d  = HANDLE_WIDTH'(req_i.item);
        pos_d  = count_q[AW-1:0];
        rd_en  = (count_q != '0);
        rd_log = count_m1[AW-1:0];
      end
      OP_START_REM: begin
        rd_en  = 1'b1;
        rd_log = '0;
      end
      OP_SHIFT: begin
        // Move the entry read last one place back and fetch the next one.
        wr_en   = 1'b1;
        wr_data = rd_q;
        pos_d   = pos_q - AW'(1);
        rd_en   = ({1'b0, pos_q} >= (AW+1)'(2));
        rd_log  = pos_q - AW'(2);
      end
      OP_PLACE: begin
        wr_en           = 1'b1;
        wr_data.level   = lvl_q;
        wr_data.handle  = hdl_q;
        count_d         = count_p1;
        valid_d         = 1'b1;
        res_d.status    = STAT_DONE;
        res_d.item_out  = '0;
        res_d.level_out = '0;
        res_d.occupancy = OCC_W'(count_p1);
      end
      OP_POP: begin
        head_d          = (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
        count_d         = count_m1;
        valid_d         = 1'b1;
        res_d.status    = STAT_DONE;
        res_d.item_out  = 16'(rd_q.handle);
        res_d.level_out = 8'(rd_q.level);
        res_d.occupancy = OCC_W'(count_m1);
      end
      OP_FULL: begin
        valid_d         = 1'b1;
        res_d.status    = STAT_FULL;
        res_d.item_out  = '0;
        res_d.level_out = '0;
        res_d.occupancy = OCC_W'(count_q);
      end
      OP_EMPTY: begin
        valid_d         = 1'b1;
        res_d.status    = STAT_EMPTY;
        res_d.item_out  = '0;
        res_d.level_out = '0;
        res_d.occupancy = '0;
      end
      default: begin
      end
    endcase
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[phys(head_q, pos_q)] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[phys(head_q, rd_log)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      head_q  <= '0;
      pos_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      head_q  <= head_d;
      pos_q   <= pos_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q <= lvl_d;
    hdl_q <= hdl_d;
    res_q <= res_d;
  end

  assign done_o   = valid_q;
  assign result_o = res_q;

endmodule

FILE: sv/spq_ctrl.sv
// Controller of the stable priority queue unit: sequences an insert scan
// or a head removal and issues one datapath operation per cycle.
// Depends on spq_pkg.
module spq_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  logic           kind_i,
  input  spq_pkg::stat_t stat_i,
  output spq_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import spq_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = OP_NONE;
    busy_o    = (state_q != S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (kind_i == KIND_REMOVE) begin
            if (stat_i.empty) begin
              cmd_o.op = OP_EMPTY;
            end else begin
              cmd_o.op = OP_START_REM;
              state_d  = S_POP;
            end
          end else if (stat_i.full) begin
            cmd_o.op = OP_FULL;
          end else begin
            cmd_o.op = OP_START_INS;
            state_d  = stat_i.empty ? S_PLACE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (stat_i.goes_before) begin
          cmd_o.op = OP_SHIFT;
          if (stat_i.pos_one) begin
            state_d = S_PLACE;
          end
        end else begin
          cmd_o.op = OP_PLACE;
          state_d  = S_IDLE;
        end
      end
      S_PLACE: begin
        cmd_o.op = OP_PLACE;
        state_d  = S_IDLE;
      end
      S_POP: begin
        cmd_o.op = OP_POP;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

FILE: sv/stable_priority_queue_unit.sv
// Top level of the stable priority queue unit: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//   Channel   Direction  Handshake            Payload
//   request   in         start high, busy low  req_i    (kind, level, item)
//   result    out        done_o, one cycle     result_o (status, item_out,
//                                                        level_out, occupancy)
//
// Sequence: a remove of a stored entry reads the head entry on acceptance and
// pops it in S_POP, its result strobed after the pop. An insert moves each
// entry with a strictly lower level one place back in S_SCAN, limited by the
// single port pair of the entry memory: each moved entry costs one read and one
// write. A refused insert or a remove from an empty queue never leaves idle.
// Reset clears the count, the head pointer, the state and the strobe; the
// entry memory is not cleared, since only entries below the count are read.
// The receiver cannot stall: each result is shown for exactly one cycle.
module stable_priority_queue_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  spq_pkg::req_t    req_i,
  output logic             done_o,
  output spq_pkg::result_t result_o
);
  import spq_pkg::*;

  // The queue is a ring in memory: a remove only advances the head, and an
  // insert walks from the tail toward the head, moving each entry with a
  // strictly lower level one place back until the new entry's slot is found.
  cmd_t  cmd;
  stat_t stat;

  spq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .kind_i  (req_i.kind),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  spq_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

FILE: sv/spq_checker.sv
// Port-level checks for the stable priority queue unit, bound to the top.
// Depends on spq_pkg and stable_priority_queue_unit.
module spq_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input spq_pkg::result_t result_o
);
  import spq_pkg::*;

  // A result marks the return to idle.
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while busy");

  // The block only becomes busy right after accepting an item.
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted item");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (result_o.status == STAT_DONE || result_o.status == STAT_EMPTY ||
                result_o.status == STAT_FULL))
    else $error("unknown status code");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == STAT_EMPTY) |->
      (result_o.occupancy == '0 && result_o.item_out == '0 &&
       result_o.level_out == '0))
    else $error("empty result carries data");

  a_full_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status == STAT_FULL) |->
      (result_o.occupancy == OCC_W'(CAPACITY) && result_o.item_out == '0))
    else $error("full result with wrong occupancy");

endmodule

bind stable_priority_queue_unit spq_checker u_spq_checker (.*);

FILE: verif/tb_stable_priority_queue_unit.sv
// Self-checking testbench for stable_priority_queue_unit: directed and random
// insert/remove traffic, checked result by result against an in-bench queue.
// Depends on spq_pkg and the RTL of the unit; reads and writes no files.
module tb_stable_priority_queue_unit;
  import spq_pkg::*;

  // A cycle with no accepted item and no result counts toward this limit.
  // The slowest legitimate quiet stretch is the longest sender gap plus an
  // insert that shifts every stored entry, so this leaves a wide margin.
  localparam int STALL_LIMIT = 1000;

  // Cycles to wait after the last expected result, above the longest insert.
  localparam int TAIL_CYCLES = 24;

  logic    clk_i = 1'b0;
  logic    rst_ni;
  logic    start;
  logic    busy;
  req_t    req_i;
  logic    done_o;
  result_t result_o;

  // In-bench copy of the queue contents, head at index zero.
  logic [HANDLE_WIDTH-1:0] queue_handles [CAPACITY];
  logic [LEVEL_WIDTH-1:0]  queue_levels  [CAPACITY];
  int                      queue_depth = 0;

  // Results predicted for accepted items and not yet seen on the outputs.
  result_t awaited_results [$];

  int error_count  = 0;
  int stall_cycles = 0;

  stable_priority_queue_unit u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .req_i    (req_i),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one item to the in-bench queue and returns the result it should
  // produce. An insert goes in front of the first entry with a strictly
  // lower level, so equal levels stay in arrival order.
  function automatic result_t serve_request(input req_t r);
    result_t res;
    int      pos;
    res = '0;
    if (r.kind == KIND_INSERT) begin
      if (queue_depth >= CAPACITY) begin
        // A full queue refuses the insert and keeps its contents.
        res.status = STAT_FULL;
      end else begin
        pos = queue_depth;
        for (int i = 0; i < queue_depth; i++) begin
          if (pos == queue_depth && r.level > queue_levels[i]) pos = i;
        end
        for (int i = queue_depth; i > pos; i--) begin
          queue_handles[i] = queue_handles[i-1];
          queue_levels[i]  = queue_levels[i-1];
        end
        queue_handles[pos] = r.item;
        queue_levels[pos]  = r.level;
        queue_depth++;
        res.status = STAT_DONE;
      end
    end else if (queue_depth == 0) begin
      // Removing from an empty queue reports empty with zero payload.
      res.status = STAT_EMPTY;
    end else begin
      res.status    = STAT_DONE;
      res.item_out  = queue_handles[0];
      res.level_out = queue_levels[0];
      for (int i = 1; i < queue_depth; i++) begin
        queue_handles[i-1] = queue_handles[i];
        queue_levels[i-1]  = queue_levels[i];
      end
      queue_depth--;
    end
    res.occupancy = queue_depth[OCC_W-1:0];
    return res;
  endfunction

  // Outputs are sampled at the rising edge, before the block updates them.
  // A result is checked before the item accepted at the same edge is
  // predicted, since that result always belongs to an earlier item.
  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (awaited_results.size() == 0) begin
          $error("result strobed with no item outstanding: %h", result_o);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          if (result_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_o.status);
            error_count++;
          end
          if (result_o.item_out !== want.item_out) begin
            $error("item_out: expected %h, got %h", want.item_out, result_o.item_out);
            error_count++;
          end
          if (result_o.level_out !== want.level_out) begin
            $error("level_out: expected %0d, got %0d", want.level_out, result_o.level_out);
            error_count++;
          end
          if (result_o.occupancy !== want.occupancy) begin
            $error("occupancy: expected %0d, got %0d", want.occupancy, result_o.occupancy);
            error_count++;
          end
        end
      end
      if (start && !busy) awaited_results.push_back(serve_request(req_i));
    end
  end

  // The watchdog ends a run that has stopped making progress.
  always @(posedge clk_i) begin
    if (!rst_ni || done_o || (start && !busy)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Presents one item and returns right after the edge that accepts it.
  // Start stays high on return so that back-to-back items need no gap.
  task automatic send_request(input req_t r);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic idle_for(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  // Waits until every accepted item has produced its result. The first edge
  // is always taken, so an item accepted at the current edge is counted.
  task automatic wait_all_served();
    start <= 1'b0;
    do @(posedge clk_i); while (awaited_results.size() != 0);
  endtask

  task automatic send_fields(input kind_e k, input logic [7:0] lvl,
                             input logic [15:0] hnd);
    req_t r;
    r.kind  = k;
    r.level = lvl;
    r.item  = hnd;
    send_request(r);
  endtask

  // Removing right after reset must report an empty queue.
  task automatic test_empty_remove();
    send_fields(KIND_REMOVE, 8'hFF, 16'hFFFF);
  endtask

  // Extreme levels and handles, and two equal levels that must leave in
  // the order they came in.
  task automatic test_stable_order();
    send_fields(KIND_INSERT, 8'h00, 16'h0000);
    send_fields(KIND_INSERT, 8'hFF, 16'hFFFF);
    send_fields(KIND_INSERT, 8'h07, 16'h0A01);
    send_fields(KIND_INSERT, 8'h07, 16'h0A02);
    repeat (4) send_fields(KIND_REMOVE, 8'h00, 16'h0000);
  endtask

  // Ascending levels put every insert at the head, so each one shifts the
  // whole queue. The insert after the queue fills up must be refused.
  task automatic test_fill_to_overflow();
    for (int i = 1; i <= CAPACITY; i++) begin
      send_fields(KIND_INSERT, 8'(i), 16'h1000 + 16'(i));
    end
    send_fields(KIND_INSERT, 8'hFF, 16'hBEEF);
    send_fields(KIND_REMOVE, 8'h00, 16'h0000);
  endtask

  // The sender holds off until the queue has answered everything, then
  // resumes with a short burst.
  task automatic test_pause_until_idle();
    wait_all_served();
    send_fields(KIND_INSERT, 8'h80, 16'h5A5A);
    send_fields(KIND_REMOVE, 8'h00, 16'h0000);
    wait_all_served();
  endtask

  // Random traffic in phases. Fill phases push the queue toward full, drain
  // phases toward empty, so both boundaries are hit repeatedly. Levels come
  // from a narrow range in some phases to produce many ties.
  task automatic test_random_traffic(input int n_items, input bit allow_idle);
    int   sent;
    int   phase_len;
    int   insert_pct;
    int   level_mode;
    bit   idle_on;
    req_t r;
    sent = 0;
    while (sent < n_items) begin
      phase_len = $urandom_range(8, 60);
      case ($urandom_range(0, 3))
        0: begin
          insert_pct = 85;
        end
        1: begin
          insert_pct = 15;
        end
        default: begin
          insert_pct = 50;
        end
      endcase
      level_mode = $urandom_range(0, 2);
      idle_on    = allow_idle && ($urandom_range(0, 2) != 0);
      for (int k = 0; k < phase_len && sent < n_items; k++) begin
        r.kind = ($urandom_range(0, 99) < insert_pct) ? KIND_INSERT : KIND_REMOVE;
        case (level_mode)
          0: begin
            r.level = 8'($urandom_range(0, 3));
          end
          1: begin
            r.level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          end
          default: begin
            r.level = 8'($urandom_range(0, 255));
          end
        endcase
        r.item = 16'($urandom_range(0, 65535));
        send_request(r);
        sent++;
        if (idle_on && $urandom_range(0, 5) == 0) idle_for($urandom_range(1, 18));
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    start  <= 1'b0;
    req_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_remove();
    test_stable_order();
    test_fill_to_overflow();
    test_random_traffic(600, 1'b1);
    test_pause_until_idle();
    test_random_traffic(550, 1'b1);
    // The last stretch runs without gaps to keep the block saturated.
    test_random_traffic(150, 1'b0);

    wait_all_served();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (error_count == 0 && awaited_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
sv/spq_pkg.sv
sv/spq_datapath.sv
sv/spq_ctrl.sv
sv/stable_priority_queue_unit.sv
sv/spq_checker.sv
verif/tb_stable_priority_queue_unit.sv
